FILE: rtl/jfs_pkg.sv
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared constants and types for the joint fold/stand ramp sequencer.
// ----------------------------------------------------------------------------
package jfs_pkg;

	localparam int JOINTS          = 8;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int JW              = 4;   // joint index width
	localparam int AW              = 16;  // angle / gain width
	localparam int QW              = 18;  // ramp quotient width
	localparam int PW              = 50;  // ramp dividend width
	localparam int LW              = 32;  // ramp length / counter width

	typedef enum logic [1:0] {
		PH_FOLD  = 2'd0,
		PH_STAND = 2'd1,
		PH_ROLL  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ENTER = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	localparam logic [1:0] CFG_FOLD_RATE   = 2'd0;
	localparam logic [1:0] CFG_STAND_TICKS = 2'd1;
	localparam logic [1:0] CFG_SETTLE      = 2'd2;

	typedef struct packed {
		logic signed [AW-1:0] fold;
		logic signed [AW-1:0] stand;
		logic        [AW-1:0] gain_p;
		logic        [AW-1:0] gain_d;
		logic signed [AW-1:0] ff;
	} tab_entry_t;

	typedef struct packed {
		logic          tab_we;
		logic          start_we;
		logic [JW-1:0] waddr;
		logic [JW-1:0] raddr;
	} mem_ctl_t;

endpackage

FILE: rtl/jfs_tables.sv
// ----------------------------------------------------------------------------
// jfs_tables
// Per-joint parameter table and start-angle table, synchronous read.
// ----------------------------------------------------------------------------
module jfs_tables import jfs_pkg::*; (
	input  logic                 clk,
	input  mem_ctl_t             ctl,
	input  tab_entry_t           tab_wdata,
	input  logic signed [AW-1:0] start_wdata,
	output tab_entry_t           tab_rdata,
	output logic signed [AW-1:0] start_rdata
);

	tab_entry_t           tab_mem [2**JW];
	logic signed [AW-1:0] start_mem [2**JW];

	always_ff @(posedge clk) begin
		if (ctl.tab_we) begin
			tab_mem[ctl.waddr] <= tab_wdata;
		end
		if (ctl.start_we) begin
			start_mem[ctl.waddr] <= start_wdata;
		end
		tab_rdata   <= tab_mem[ctl.raddr];
		start_rdata <= start_mem[ctl.raddr];
	end

endmodule

FILE: rtl/jfs_ramp_div.sv
// ----------------------------------------------------------------------------
// jfs_ramp_div
// Restoring divider for the ramp fraction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jfs_ramp_div import jfs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] dividend,
	input  logic [LW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quot
);

	logic [PW-1:0] rem_q;
	logic [PW-1:0] dv_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          ge;

	assign ge = rem_q >= dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= !start && busy_q && cnt_q == '0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// divisor starts aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dv_q  <= PW'({divisor, {(QW-1){1'b0}}});
			quot  <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			dv_q <= dv_q >> 1;
			quot <= {quot[QW-2:0], ge};
		end
	end

endmodule

FILE: rtl/joint_fold_stand_ramp_sequencer.sv
// ----------------------------------------------------------------------------
// joint_fold_stand_ramp_sequencer
// Stand-up sequencer: per-joint tables, fold/stand/roll-over phases, linear
// setpoint ramps toward the phase target.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   load / enter / tick request, tuser = req_type
//  m_axis    out  one joint command, tuser = phase, tlast = last joint
//  cfg       in   register write, no read-back
//
// Load and plain enter beats keep it idle. An enter beat with tlast sweeps
// the joints with a read and an accumulate step each, then a multiply step.
// Each tick joint: read, latch, multiply, 18-step ramp divide, output.
// Input is taken only between items; a stalled output holds the sequencer.
// Reset leaves the tables undefined and clears counters, mask and phase.
// ----------------------------------------------------------------------------
module joint_fold_stand_ramp_sequencer import jfs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// joint_index, measured_position, fold_position, stand_position,
	// stiffness_gain, damping_gain, feedforward_torque, is_wheel, upside_down
	input  logic [103:0] s_tdata,
	input  logic [1:0]   s_tuser,  // req_type
	input  logic         s_tlast,  // last_joint
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_joint, position_command, stiffness_command, damping_command,
	// torque_command, ready_to_leave
	output logic [71:0]  m_tdata,
	output logic [1:0]   m_tuser,  // phase
	output logic         m_tlast,  // last_command
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_GAP_RD  = 8'b0000_0010,
		ST_GAP_ACC = 8'b0000_0100,
		ST_GAP_MUL = 8'b0000_1000,
		ST_TK_RD   = 8'b0001_0000,
		ST_TK_LAT  = 8'b0010_0000,
		ST_TK_MUL  = 8'b0100_0000,
		ST_TK_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   div_wait_q;
	logic   div_go_q;

	// input fields
	logic [JW-1:0]        in_joint;
	logic signed [AW-1:0] in_meas;
	tab_entry_t           in_tab;
	logic                 in_wheel;
	logic                 in_upside;
	logic                 in_valid_joint;
	logic                 acc;

	assign in_joint       = s_tdata[3:0];
	assign in_meas        = s_tdata[19:4];
	assign in_tab.fold    = s_tdata[35:20];
	assign in_tab.stand   = s_tdata[51:36];
	assign in_tab.gain_p  = s_tdata[67:52];
	assign in_tab.gain_d  = s_tdata[83:68];
	assign in_tab.ff      = s_tdata[99:84];
	assign in_wheel       = s_tdata[100];
	assign in_upside      = s_tdata[101];
	assign in_valid_joint = 5'(in_joint) < 5'(JOINTS);

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// registers and state
	logic [15:0]   fold_rate_q, stand_ticks_q, settle_q;
	logic [15:0]   wheel_q;
	logic [16:0]   gap_q;
	logic [LW-1:0] fold_ramp_q, tick_q, ms_q;
	phase_t        phase_q;

	// tick working set
	phase_t        ph_q;
	logic [LW-1:0] cur_q, len_q;
	logic          trans_q, imm_q, ready_q;
	logic [JW-1:0] j_q;

	logic signed [AW-1:0] start_s2, tgt_s2, ff_s2;
	logic [AW-1:0]        kp_s2, kd_s2;
	logic [16:0]          mag_s2;
	logic                 neg_s2, wheel_s2;
	logic [PW-1:0]        prod_s3;

	// memories
	mem_ctl_t             mctl;
	tab_entry_t           tab_rd;
	logic signed [AW-1:0] start_rd, start_wd;

	always_comb begin
		mctl.tab_we   = acc && s_tuser == REQ_LOAD && in_valid_joint;
		mctl.start_we = (acc && s_tuser == REQ_ENTER && in_valid_joint)
		                || (state_q == ST_TK_LAT && trans_q);
		mctl.waddr    = (state_q == ST_IDLE) ? in_joint : j_q;
		mctl.raddr    = j_q;
		start_wd      = (state_q == ST_IDLE) ? in_meas : tab_rd.fold;
	end

	jfs_tables u_tables (
		.clk         (clk),
		.ctl         (mctl),
		.tab_wdata   (in_tab),
		.start_wdata (start_wd),
		.tab_rdata   (tab_rd),
		.start_rdata (start_rd)
	);

	logic          div_start, div_done;
	logic [QW-1:0] div_q;

	// product is registered first, the divider starts on the next cycle
	assign div_start = div_go_q;

	jfs_ramp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_s3),
		.divisor  (len_q),
		.done     (div_done),
		.quot     (div_q)
	);

	// combinational helpers
	logic [LW-1:0]        cur_n;
	logic signed [16:0]   gdiff, tdiff;
	logic [16:0]          gabs;
	logic signed [AW-1:0] tgt_rd;
	logic [32:0]          ramp_prod;
	logic [LW-1:0]        settle_diff;
	logic signed [AW-1:0] ramp_pos, pos_out, tq_out;
	logic [AW-1:0]        kp_out, kd_out;
	logic                 last_j;

	always_comb begin
		cur_n       = tick_q - ms_q;
		gdiff       = 17'(start_rd) - 17'(tab_rd.fold);
		gabs        = gdiff[16] ? 17'(-gdiff) : 17'(gdiff);
		tgt_rd      = (ph_q == PH_FOLD) ? tab_rd.fold : tab_rd.stand;
		tdiff       = 17'(tgt_rd) - 17'(start_rd);
		ramp_prod   = 33'(fold_rate_q) * 33'(gap_q);
		settle_diff = tick_q - fold_ramp_q - LW'(stand_ticks_q);
		last_j      = 5'(j_q) == 5'(JOINTS - 1);
		ramp_pos    = imm_q ? tgt_s2 :
		              neg_s2 ? start_s2 - AW'(div_q) : start_s2 + AW'(div_q);
		if (ph_q == PH_ROLL) begin
			pos_out = '0; kp_out = '0; kd_out = '0; tq_out = '0;
		end else if (wheel_s2) begin
			pos_out = '0; kp_out = '0; kd_out = kd_s2; tq_out = '0;
		end else begin
			pos_out = ramp_pos; kp_out = kp_s2; kd_out = kd_s2; tq_out = ff_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_wait_q    <= 1'b0;
			div_go_q      <= 1'b0;
			fold_rate_q   <= 16'd500;
			stand_ticks_q <= 16'd500;
			settle_q      <= 16'd100;
			wheel_q       <= '0;
			gap_q         <= '0;
			fold_ramp_q   <= '0;
			tick_q        <= '0;
			ms_q          <= '0;
			phase_q       <= PH_FOLD;
			m_tvalid      <= 1'b0;
			j_q           <= '0;
		end else begin
			if (state_q == ST_TK_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			div_go_q <= (state_q == ST_TK_MUL) && !div_wait_q;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FOLD_RATE:   fold_rate_q   <= cfg_data;
					CFG_STAND_TICKS: stand_ticks_q <= cfg_data;
					CFG_SETTLE:      settle_q      <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					j_q <= '0;
					if (acc) begin
						case (s_tuser)
							REQ_LOAD: begin
								if (in_valid_joint) begin
									wheel_q[in_joint] <= in_wheel;
								end
							end
							REQ_ENTER: begin
								if (s_tlast) begin
									gap_q   <= '0;
									tick_q  <= '0;
									ms_q    <= '0;
									phase_q <= in_upside ? PH_ROLL : PH_FOLD;
									state_q <= ST_GAP_RD;
								end
							end
							REQ_TICK: begin
								ph_q    <= phase_q;
								cur_q   <= cur_n;
								len_q   <= (phase_q == PH_FOLD) ? fold_ramp_q
								           : LW'(stand_ticks_q);
								trans_q <= phase_q == PH_FOLD && cur_n >= fold_ramp_q;
								if (phase_q == PH_FOLD && cur_n >= fold_ramp_q) begin
									phase_q <= in_upside ? PH_ROLL : PH_STAND;
									ms_q    <= tick_q + LW'(1);
								end
								tick_q  <= tick_q + LW'(1);
								state_q <= ST_TK_RD;
							end
							default: ;
						endcase
					end
				end
				ST_GAP_RD: state_q <= ST_GAP_ACC;
				ST_GAP_ACC: begin
					if (!wheel_q[j_q] && gabs > gap_q) begin
						gap_q <= gabs;
					end
					j_q     <= j_q + JW'(1);
					state_q <= last_j ? ST_GAP_MUL : ST_GAP_RD;
				end
				ST_GAP_MUL: begin
					fold_ramp_q <= LW'(ramp_prod >> ANGLE_FRAC_BITS);
					state_q     <= ST_IDLE;
				end
				ST_TK_RD: begin
					imm_q   <= len_q == '0 || cur_q >= len_q;
					ready_q <= !settle_diff[LW-1] && settle_diff >= LW'(settle_q);
					state_q <= ST_TK_LAT;
				end
				ST_TK_LAT: state_q <= ST_TK_MUL;
				ST_TK_MUL: begin
					if (div_done) begin
						div_wait_q <= 1'b0;
						state_q    <= ST_TK_OUT;
					end else begin
						div_wait_q <= 1'b1;
					end
				end
				ST_TK_OUT: begin
					if (!m_tvalid || m_tready) begin
						j_q      <= j_q + JW'(1);
						state_q  <= last_j ? ST_IDLE : ST_TK_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// joint operands, then the ramp product, then the output beat
	always_ff @(posedge clk) begin
		if (state_q == ST_TK_LAT) begin
			start_s2 <= start_rd;
			tgt_s2   <= tgt_rd;
			kp_s2    <= tab_rd.gain_p;
			kd_s2    <= tab_rd.gain_d;
			ff_s2    <= tab_rd.ff;
			wheel_s2 <= wheel_q[j_q];
			neg_s2   <= tdiff[16];
			mag_s2   <= tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
		end
		if (state_q == ST_TK_MUL && !div_wait_q) begin
			prod_s3 <= PW'(49'(mag_s2) * 49'(cur_q)) + PW'(len_q[LW-1:1]);
		end
		if (state_q == ST_TK_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {3'b000, ready_q, tq_out, kd_out, kp_out, pos_out, j_q};
			m_tuser <= ph_q;
			m_tlast <= last_j;
		end
	end

endmodule
